/* rtl/rgb_shp_pkg.sv */
// Shared types, constants and register indexes for the RGB 3x3 sharpen block.
`default_nettype none
package rgb_shp_pkg;

  // Geometry limits
  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 4096;

  // Field widths
  localparam int COL_W  = 11;
  localparam int ROW_W  = 13;
  localparam int CFG_W  = 13;
  localparam int ADDR_W = $clog2(MAX_COLUMNS);
  localparam int PIX_W  = 24;

  // Register reset values
  localparam logic [COL_W-1:0] COLUMNS_RESET = COL_W'(500);
  localparam logic [ROW_W-1:0] ROWS_RESET    = ROW_W'(281);

  // Register indexes
  typedef enum logic [0:0] {
    REG_COLUMNS = 1'b0,
    REG_ROWS    = 1'b1
  } reg_index_t;

  // One RGB pixel: red in the low byte, blue in the high byte
  typedef logic [PIX_W-1:0] pix_t;

  // One window column: pixel two rows up, one row up, current row
  typedef struct packed {
    pix_t top;
    pix_t mid;
    pix_t bot;
  } col_t;

  // Per-item tag computed at input time and carried down the pipe
  typedef struct packed {
    logic emit;
    logic sharp;
    logic last;
  } tag_t;

endpackage
`default_nettype wire

/* rtl/rgb_sharpen_3x3_top.sv */
// Top level of the streaming RGB 3x3 sharpen block.
//
// Pixels enter in raster order on the s_ group, one beat per pixel; s_tuser
// marks a flush beat (no pixel, advance only). Results leave on the m_ group,
// m_tlast on the last pixel of the frame. After each frame the host sends
// columns+1 flush beats to drain the final row and pixel.
// The result for a pixel leaves after columns+1 further input beats (the first
// columns+1 beats of a frame give no result) and then passes the line-store
// read, the window shift and the output register. Throughput is one beat per
// cycle while m_tready does not stall the output; the line-store memory is read
// and written once per beat and the window is a chain of three column cells.
// Reset (synchronous, rst high) clears all position counters and valid flags,
// sets columns to 500 and rows to 281; the line stores are not cleared and
// no clearing pass runs. The config port takes writes at any edge with
// cfg_we high; write it only while the block is idle.
// When m_tready is low the output register holds its beat, the two inner
// stages still fill, and s_tready drops once they are full.
`default_nettype none
module rgb_sharpen_3x3_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Configuration write port
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [rgb_shp_pkg::CFG_W-1:0] cfg_wdata,
  // Input stream
  input  wire logic                          s_tvalid,
  output      logic                          s_tready,
  input  wire logic [23:0]                   s_tdata,  // red_in, green_in, blue_in
  input  wire logic                          s_tuser,  // flush
  // Output stream
  output      logic                          m_tvalid,
  input  wire logic                          m_tready,
  output      logic [23:0]                   m_tdata,  // red_out, green_out, blue_out
  output      logic                          m_tlast   // frame_end
);
  import rgb_shp_pkg::*;

  // Configuration, stored already clamped to the legal range
  logic [COL_W-1:0] cols_eff;
  logic [ROW_W-1:0] rows_eff;

  // Position counters
  logic [COL_W-1:0] in_column, in_column_next;
  logic [ROW_W-1:0] in_row, in_row_next;
  logic [COL_W-1:0] out_column, out_column_next;
  logic [ROW_W-1:0] out_row, out_row_next;

  // Pipeline stages
  logic              s1v;
  pix_t              s1_pix;
  logic [ADDR_W-1:0] s1_addr;
  tag_t              s1_tag;
  logic              s2v;
  tag_t              s2_tag;

  // Handshake and stage enables
  logic s_accept, out_free, s2_free, s2_take;

  // Stage-0 decode
  logic [COL_W-1:0]  cols_m1;
  logic [ADDR_W-1:0] rd_addr;
  logic [COL_W:0]    in_col_inc, out_col_inc;
  logic [ROW_W:0]    out_row_inc;
  tag_t              tag_now;
  pix_t              pix_now;

  // Line store and window
  logic [2*PIX_W-1:0] rd_data;
  col_t               new_col, w_old, w_ctr, w_new;
  pix_t               sharp_res;

  // Stage enables: the window holds one pending result
  assign out_free = !m_tvalid || m_tready;
  assign s2_free  = !s2v || !s2_tag.emit || out_free;
  assign s2_take  = s1v && s2_free;
  assign s_tready = !s1v || s2_take;
  assign s_accept = s_tvalid && s_tready;

  // Write clamped configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_eff <= COLUMNS_RESET;
      rows_eff <= ROWS_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_COLUMNS: begin
          if (cfg_wdata[COL_W-1:0] < COL_W'(3)) begin
            cols_eff <= COL_W'(3);
          end else if (cfg_wdata[COL_W-1:0] > COL_W'(MAX_COLUMNS)) begin
            cols_eff <= COL_W'(MAX_COLUMNS);
          end else begin
            cols_eff <= cfg_wdata[COL_W-1:0];
          end
        end
        REG_ROWS: begin
          if (cfg_wdata[ROW_W-1:0] < ROW_W'(3)) begin
            rows_eff <= ROW_W'(3);
          end else if (cfg_wdata[ROW_W-1:0] > ROW_W'(MAX_ROWS)) begin
            rows_eff <= ROW_W'(MAX_ROWS);
          end else begin
            rows_eff <= cfg_wdata[ROW_W-1:0];
          end
        end
        default: begin
          cols_eff <= cols_eff;
        end
      endcase
    end
  end

  // Decode position of the incoming beat
  always_comb begin
    pix_now     = s_tuser ? '0 : pix_t'(s_tdata);
    cols_m1     = cols_eff - COL_W'(1);
    rd_addr     = (in_column < cols_eff) ? in_column[ADDR_W-1:0] : cols_m1[ADDR_W-1:0];
    in_col_inc  = {1'b0, in_column} + (COL_W+1)'(1);
    out_col_inc = {1'b0, out_column} + (COL_W+1)'(1);
    out_row_inc = {1'b0, out_row} + (ROW_W+1)'(1);

    tag_now.emit  = (in_row >= ROW_W'(2)) ||
                    ((in_row == ROW_W'(1)) && (in_column != '0));
    tag_now.sharp = (out_row != '0) && (out_row_inc < {1'b0, rows_eff}) &&
                    (out_column != '0) && (out_col_inc < {1'b0, cols_eff});
    tag_now.last  = (out_row_inc >= {1'b0, rows_eff}) &&
                    (out_col_inc >= {1'b0, cols_eff});
  end

  // Next counter values
  always_comb begin
    if (in_col_inc >= {1'b0, cols_eff}) begin
      in_column_next = '0;
      in_row_next    = in_row + ROW_W'(1);
    end else begin
      in_column_next = in_col_inc[COL_W-1:0];
      in_row_next    = in_row;
    end
    out_column_next = out_column;
    out_row_next    = out_row;
    if (tag_now.emit) begin
      if (tag_now.last) begin
        in_column_next  = '0;
        in_row_next     = '0;
        out_column_next = '0;
        out_row_next    = '0;
      end else if (out_col_inc >= {1'b0, cols_eff}) begin
        out_column_next = '0;
        out_row_next    = out_row_inc[ROW_W-1:0];
      end else begin
        out_column_next = out_col_inc[COL_W-1:0];
      end
    end
  end

  // Advance counters on each accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else if (s_accept) begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  // Read stage: hold the beat while the line store is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
    end else if (s_tready) begin
      s1v <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_pix  <= pix_now;
      s1_addr <= rd_addr;
      s1_tag  <= tag_now;
    end
  end

  rgb_shp_line_store u_line_store (
    .clk     (clk),
    .rd_en   (s_accept),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (s2_take),
    .wr_addr (s1_addr),
    .wr_data ({rd_data[PIX_W-1:0], s1_pix})
  );

  // Window stage: shift a column in as the beat leaves the read stage
  assign new_col.top = rd_data[2*PIX_W-1:PIX_W];
  assign new_col.mid = rd_data[PIX_W-1:0];
  assign new_col.bot = s1_pix;

  rgb_shp_win_cell u_cell_new (
    .clk (clk), .rst (rst), .en (s2_take), .d (new_col), .q (w_new)
  );
  rgb_shp_win_cell u_cell_ctr (
    .clk (clk), .rst (rst), .en (s2_take), .d (w_new), .q (w_ctr)
  );
  rgb_shp_win_cell u_cell_old (
    .clk (clk), .rst (rst), .en (s2_take), .d (w_ctr), .q (w_old)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2v <= 1'b0;
    end else if (s2_take) begin
      s2v <= 1'b1;
    end else if (s2_free) begin
      s2v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take) begin
      s2_tag <= s1_tag;
    end
  end

  rgb_shp_sharpen u_sharpen (
    .w_old (w_old),
    .w_ctr (w_ctr),
    .w_new (w_new),
    .sharp (s2_tag.sharp),
    .res   (sharp_res)
  );

  // Output register: load a result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s2v && s2_tag.emit && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2v && s2_tag.emit && out_free) begin
      m_tdata <= sharp_res;
      m_tlast <= s2_tag.last;
    end
  end

  // A pending result stays in the window until the output register frees
  a_hold_window: assert property (@(posedge clk) disable iff (rst)
    (s2v && s2_tag.emit && !out_free) |=> (s2v && $stable(s2_tag) && $stable(w_ctr)))
    else $error("pending window result lost");

  // A stalled read-stage beat keeps its line-store address
  a_hold_read: assert property (@(posedge clk) disable iff (rst)
    (s1v && !s2_take) |=> (s1v && $stable(s1_addr) && $stable(s1_pix)))
    else $error("read stage beat changed while stalled");

  // The frame's last beat returns every counter to zero
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (s_accept && tag_now.emit && tag_now.last) |=>
      (in_column == '0 && in_row == '0 && out_column == '0 && out_row == '0))
    else $error("counters not cleared at frame end");

endmodule
`default_nettype wire

/* rtl/rgb_shp_line_store.sv */
// Two line stores packed side by side in one memory, with write-first read.
`default_nettype none
module rgb_shp_line_store (
  input  wire logic                              clk,
  input  wire logic                              rd_en,
  input  wire logic [rgb_shp_pkg::ADDR_W-1:0]    rd_addr,
  output      logic [2*rgb_shp_pkg::PIX_W-1:0]  rd_data,
  input  wire logic                              wr_en,
  input  wire logic [rgb_shp_pkg::ADDR_W-1:0]    wr_addr,
  input  wire logic [2*rgb_shp_pkg::PIX_W-1:0]  wr_data
);
  import rgb_shp_pkg::*;

  // Each entry holds {older row, newer row} for one column
  logic [2*PIX_W-1:0] mem [MAX_COLUMNS];

  // Write the column once its item leaves the read stage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Register the read; take the word being written when addresses collide
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/rgb_shp_win_cell.sv */
// One column cell of the 3x3 window; loads from its right-hand neighbor.
`default_nettype none
module rgb_shp_win_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire rgb_shp_pkg::col_t  d,
  output      rgb_shp_pkg::col_t  q
);
  import rgb_shp_pkg::*;

  // Shift one column per advancing item
  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (en) begin
      q <= d;
    end
  end

endmodule
`default_nettype wire

/* rtl/rgb_shp_sharpen.sv */
// Laplacian sharpen of the window center, per channel, with border pass-through.
`default_nettype none
module rgb_shp_sharpen (
  input  wire rgb_shp_pkg::col_t  w_old,
  input  wire rgb_shp_pkg::col_t  w_ctr,
  input  wire rgb_shp_pkg::col_t  w_new,
  input  wire logic               sharp,
  output      rgb_shp_pkg::pix_t  res
);
  import rgb_shp_pkg::*;

  // 9 * center minus the eight neighbors, clamped to 0..255
  function automatic logic [7:0] sharpen_ch(
    input logic [7:0] c,
    input logic [7:0] n0, input logic [7:0] n1, input logic [7:0] n2,
    input logic [7:0] n3, input logic [7:0] n4, input logic [7:0] n5,
    input logic [7:0] n6, input logic [7:0] n7
  );
    logic [11:0]        nsum;
    logic [11:0]        c9;
    logic signed [13:0] v;
    logic [7:0]         r;
    nsum = (({4'd0, n0} + {4'd0, n1}) + ({4'd0, n2} + {4'd0, n3})) +
           (({4'd0, n4} + {4'd0, n5}) + ({4'd0, n6} + {4'd0, n7}));
    c9   = {1'b0, c, 3'd0} + {4'd0, c};
    v    = $signed({2'b00, c9}) - $signed({2'b00, nsum});
    if (v < 0) begin
      r = 8'd0;
    end else if (v > 14'sd255) begin
      r = 8'd255;
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // Channels are independent byte lanes
  always_comb begin
    res = w_ctr.mid;
    if (sharp) begin
      for (int k = 0; k < 3; k++) begin
        res[8*k +: 8] = sharpen_ch(w_ctr.mid[8*k +: 8],
                                   w_old.top[8*k +: 8], w_old.mid[8*k +: 8],
                                   w_old.bot[8*k +: 8], w_ctr.top[8*k +: 8],
                                   w_ctr.bot[8*k +: 8], w_new.top[8*k +: 8],
                                   w_new.mid[8*k +: 8], w_new.bot[8*k +: 8]);
      end
    end
  end

endmodule
`default_nettype wire
